// File: sv/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

	// Default sizing
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 10;

	// Depth of the queue between converter and emitter
	localparam int FIFO_DEPTH = 2;

	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = DIGIT_W'(3);

	// Double-dabble correction of one BCD digit before it is doubled
	function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		if (d >= DIGIT_FIVE) begin
			r = d + DIGIT_ADJ;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/b2da_front.sv
`default_nettype none

module b2da_front import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [VALUE_BITS-1:0]           value,
	output logic                                 ent_valid,
	input  wire logic                            ent_ready,
	output logic [MAX_DIGITS*DIGIT_W:0]          ent_data
);

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int CNT_W = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {F_IDLE, F_RUN, F_DONE} fstate_t;

	fstate_t               state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [BCD_W-1:0]      adj;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i*DIGIT_W +: DIGIT_W] = add3(bcd_q[i*DIGIT_W +: DIGIT_W]);
		end
	end

	assign full      = (state_q != F_IDLE);
	assign ent_valid = (state_q == F_DONE);
	assign ent_data  = {ovf_q, bcd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			bin_q   <= '0;
			bcd_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						bin_q   <= value;
						bcd_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= CNT_W'(VALUE_BITS - 1);
						state_q <= F_RUN;
					end
				end
				F_RUN: begin
					// shift one bit in; a carry out of the top digit marks overflow
					bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
					ovf_q <= ovf_q | adj[BCD_W-1];
					bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (ent_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/b2da_fifo.sv
`default_nettype none

module b2da_fifo import b2da_pkg::*; #(
	parameter int WIDTH = MAX_DIGITS_DEF * DIGIT_W + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/b2da_back.sv
`default_nettype none

module b2da_back import b2da_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        ent_valid,
	output logic                             ent_ready,
	input  wire logic [MAX_DIGITS*DIGIT_W:0] ent_data,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [CHAR_W-1:0]                digit_char,
	output logic                             last
);

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {B_IDLE, B_SKIP, B_EMIT} bstate_t;

	bstate_t            state_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               ovf_q;
	logic [REM_W-1:0]   rem_q;
	logic [DIGIT_W-1:0] top_digit;
	logic               one_left;

	assign top_digit  = bcd_q[BCD_W-1 -: DIGIT_W];
	assign one_left   = (rem_q == REM_W'(1));
	assign ent_ready  = (state_q == B_IDLE);
	assign empty      = (state_q != B_EMIT);
	assign digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
	assign last       = one_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bcd_q   <= '0;
			ovf_q   <= 1'b0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (ent_valid) begin
						bcd_q   <= ent_data[BCD_W-1:0];
						ovf_q   <= ent_data[BCD_W];
						rem_q   <= REM_W'(MAX_DIGITS);
						state_q <= B_SKIP;
					end
				end
				B_SKIP: begin
					// drop leading zeros, keep at least one digit; overflow keeps them all
					if (!ovf_q && !one_left && top_digit == '0) begin
						bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (pop) begin
						if (one_left) begin
							state_q <= B_IDLE;
						end else begin
							bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
							rem_q <= rem_q - REM_W'(1);
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/binary_to_decimal_ascii_top.sv
// Flow: the converter takes a new value only when idle, once its last result has gone into the
//   queue; its pace is set by the bit-serial double-dabble loop, so long as the emitter keeps
//   the queue from filling. Each further character shows in the cycle after the previous pop.
// Reset: arst_n clears both state machines and the queue at once; no clearing pass is needed.
`default_nettype none

module binary_to_decimal_ascii_top import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [CHAR_W-1:0]          digit_char,
	output logic                       last
);

	// One queue entry: an overflow flag above MAX_DIGITS packed BCD digits,
	// most significant digit at the top.
	localparam int ENTRY_W = MAX_DIGITS * DIGIT_W + 1;

	logic               fr_valid;
	logic               fr_ready;
	logic [ENTRY_W-1:0] fr_data;
	logic               bk_valid;
	logic               bk_ready;
	logic [ENTRY_W-1:0] bk_data;

	// Front: take the transaction and shift the value through the BCD
	// register one bit a cycle, adding three to every digit of five or more.
	b2da_front #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.ent_valid (fr_valid),
		.ent_ready (fr_ready),
		.ent_data  (fr_data)
	);

	// Short queue: lets the converter start the next value while the
	// emitter is still waiting on a slow consumer.
	b2da_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_data),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_data)
	);

	// Back: skip leading zero digits unless the value overflowed, then present one ASCII character per
	// transaction, flagging the least significant one as last.
	b2da_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ent_valid  (bk_valid),
		.ent_ready  (bk_ready),
		.ent_data   (bk_data),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

`default_nettype wire

// File: sv/b2da_checker.sv
`default_nettype none

module b2da_checker import b2da_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              push,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [CHAR_W-1:0] digit_char,
	input wire logic              last
);

	// Every character shown is a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + CHAR_W'(9)))
		else $error("character outside 0 to 9");

	// A waiting character holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digit_char) && $stable(last)))
		else $error("waiting character changed");

	// The converter is busy straight after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full ##1 full)
		else $error("converter not busy after transaction");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.digit_char (digit_char),
	.last       (last)
);

`default_nettype wire
